FILE: rtl/core/nsp_pkg.sv
// ----------------------------------------------------------------------------
// nsp_pkg - nearest segment pick shared types and constants
// Field widths, datapath widths, register indexes and the word layouts of
// the segment and result channels.
// ----------------------------------------------------------------------------
package nsp_pkg;

  localparam int COORD_W    = 24;
  localparam int OWNER_W    = 16;
  localparam int DIST_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // datapath widths
  localparam int DIFF_W  = COORD_W + 1;      // coordinate difference
  localparam int MUL_W   = DIFF_W + 1;       // shared multiplier operand
  localparam int PROD_W  = 2 * MUL_W;        // shared multiplier product
  localparam int SQ_W    = 2 * COORD_W + 2;  // squared length, radicand
  localparam int SUM_W   = SQ_W + 1;         // signed dot and cross sums
  localparam int HALF_W  = SQ_W / 2;         // half of a squared-width word
  localparam int NUM_W   = 2 * SQ_W;         // squared cross product
  localparam int ROOT_W  = SQ_W / 2;         // square root result
  localparam int SREM_W  = ROOT_W + 2;       // square root remainder

  localparam logic [DIST_W-1:0] RADIUS_RESET = DIST_W'(2048);
  localparam logic [DIST_W-1:0] DIST_MAX     = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINTER_X   = 2'd0,
    CFG_POINTER_Y   = 2'd1,
    CFG_PICK_RADIUS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic        [OWNER_W-1:0] owner_id;
    logic                      last_segment;
  } nsp_in_t;

  typedef struct packed {
    logic                     hit_found;
    logic [OWNER_W-1:0]       hit_owner;
    logic [DIST_W-1:0]        hit_distance;
  } nsp_out_t;

  // segment and pointer handed to the distance unit at start
  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] ptr_x;
    logic signed [COORD_W-1:0] ptr_y;
  } nsp_geom_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] distance;
  } nsp_sts_t;

endpackage

FILE: rtl/core/nsp_dist_unit.sv
// ----------------------------------------------------------------------------
// nsp_dist_unit - point to segment distance sequencer
// One shared signed multiplier builds the squared length, dot and cross
// sums, then either a squared end distance or the squared cross product;
// a restoring divider and a digit-by-digit square root finish the job.
// ----------------------------------------------------------------------------
module nsp_dist_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  nsp_pkg::nsp_geom_t geom,
  output nsp_pkg::nsp_sts_t  sts
);
  import nsp_pkg::*;

  localparam int CNT_W  = $clog2(SQ_W + 1);
  localparam int N_PROD = 6;
  localparam int N_PSQ  = 2;
  localparam int N_MSQ  = 3;

  typedef enum logic [2:0] {
    S_IDLE, S_PROD, S_PICK, S_PSQ, S_MSQ, S_DIV, S_ROOT, S_DONE
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          step_r, step_nxt;
  logic signed [DIFF_W-1:0]  ux_r, ux_nxt, uy_r, uy_nxt;
  logic signed [DIFF_W-1:0]  wx_r, wx_nxt, wy_r, wy_nxt;
  logic signed [DIFF_W-1:0]  vx_r, vx_nxt, vy_r, vy_nxt;
  logic [SQ_W-1:0]           lsq_r, lsq_nxt;
  logic signed [SUM_W-1:0]   dot_r, dot_nxt, cross_r, cross_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic [SQ_W-1:0]           mag_r, mag_nxt;
  logic [NUM_W-1:0]          acc_r, acc_nxt;
  logic [SQ_W-1:0]           rem_r, rem_nxt;
  logic [SQ_W-1:0]           quo_r, quo_nxt;
  logic [SQ_W-1:0]           rad_r, rad_nxt;
  logic [ROOT_W-1:0]         root_r, root_nxt;
  logic [SREM_W-1:0]         srem_r, srem_nxt;
  logic [DIST_W-1:0]         dist_r, dist_nxt;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic [NUM_W-1:0]          acc_add, acc_sum;
  logic [SQ_W:0]             div_trial, div_diff;
  logic                      div_ge;
  logic [SREM_W+1:0]         sq_sh, sq_trial, sq_diff;
  logic                      sq_ge;
  logic [ROOT_W-1:0]         root_step;
  logic signed [SUM_W-1:0]   cross_neg;
  logic signed [SUM_W-1:0]   lsq_s;

  function automatic logic signed [DIFF_W-1:0] ext_d(input logic signed [COORD_W-1:0] v);
    ext_d = {v[COORD_W-1], v};
  endfunction

  function automatic logic signed [MUL_W-1:0] ext_m(input logic signed [DIFF_W-1:0] v);
    ext_m = {v[DIFF_W-1], v};
  endfunction

  // shared multiplier, product registered before use
  assign prod_nxt = mul_a * mul_b;

  assign acc_sum   = acc_r + acc_add;
  assign div_trial = {rem_r, acc_r[SQ_W-1]};
  assign div_ge    = div_trial >= {1'b0, lsq_r};
  assign div_diff  = div_trial - {1'b0, lsq_r};
  assign sq_sh     = {srem_r, rad_r[SQ_W-1 -: 2]};
  assign sq_trial  = {2'b00, root_r, 2'b01};
  assign sq_ge     = sq_sh >= sq_trial;
  assign sq_diff   = sq_sh - sq_trial;
  assign root_step = {root_r[ROOT_W-2:0], sq_ge};
  assign cross_neg = -cross_r;
  assign lsq_s     = $signed({1'b0, lsq_r});

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    acc_add = NUM_W'(prod_r[PROD_W-2:0]);
    unique case (state_r)
      S_PROD: begin
        case (step_r)
          CNT_W'(0): begin mul_a = ext_m(ux_r); mul_b = ext_m(ux_r); end
          CNT_W'(1): begin mul_a = ext_m(uy_r); mul_b = ext_m(uy_r); end
          CNT_W'(2): begin mul_a = ext_m(wx_r); mul_b = ext_m(ux_r); end
          CNT_W'(3): begin mul_a = ext_m(wy_r); mul_b = ext_m(uy_r); end
          CNT_W'(4): begin mul_a = ext_m(wx_r); mul_b = ext_m(uy_r); end
          CNT_W'(5): begin mul_a = ext_m(wy_r); mul_b = ext_m(ux_r); end
          default: ;
        endcase
      end
      S_PSQ: begin
        case (step_r)
          CNT_W'(0): begin mul_a = ext_m(wx_r); mul_b = ext_m(wx_r); end
          CNT_W'(1): begin mul_a = ext_m(wy_r); mul_b = ext_m(wy_r); end
          default: ;
        endcase
      end
      S_MSQ: begin
        // magnitude split in two halves: hi*hi, hi*lo, lo*lo
        case (step_r)
          CNT_W'(0): begin
            mul_a = $signed({1'b0, mag_r[SQ_W-1:HALF_W]});
            mul_b = $signed({1'b0, mag_r[SQ_W-1:HALF_W]});
          end
          CNT_W'(1): begin
            mul_a = $signed({1'b0, mag_r[SQ_W-1:HALF_W]});
            mul_b = $signed({1'b0, mag_r[HALF_W-1:0]});
          end
          CNT_W'(2): begin
            mul_a = $signed({1'b0, mag_r[HALF_W-1:0]});
            mul_b = $signed({1'b0, mag_r[HALF_W-1:0]});
          end
          default: ;
        endcase
        case (step_r)
          CNT_W'(1): acc_add = NUM_W'(prod_r[PROD_W-2:0]) << (2 * HALF_W);
          CNT_W'(2): acc_add = NUM_W'(prod_r[PROD_W-2:0]) << (HALF_W + 1);
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ux_nxt    = ux_r;
    uy_nxt    = uy_r;
    wx_nxt    = wx_r;
    wy_nxt    = wy_r;
    vx_nxt    = vx_r;
    vy_nxt    = vy_r;
    lsq_nxt   = lsq_r;
    dot_nxt   = dot_r;
    cross_nxt = cross_r;
    mag_nxt   = mag_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    rad_nxt   = rad_r;
    root_nxt  = root_r;
    srem_nxt  = srem_r;
    dist_nxt  = dist_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ux_nxt    = ext_d(geom.end_x) - ext_d(geom.start_x);
          uy_nxt    = ext_d(geom.end_y) - ext_d(geom.start_y);
          wx_nxt    = ext_d(geom.ptr_x) - ext_d(geom.start_x);
          wy_nxt    = ext_d(geom.ptr_y) - ext_d(geom.start_y);
          vx_nxt    = ext_d(geom.ptr_x) - ext_d(geom.end_x);
          vy_nxt    = ext_d(geom.ptr_y) - ext_d(geom.end_y);
          lsq_nxt   = '0;
          dot_nxt   = '0;
          cross_nxt = '0;
          step_nxt  = '0;
          state_nxt = S_PROD;
        end
      end
      S_PROD: begin
        // accumulate the registered product issued at the previous step
        case (step_r)
          CNT_W'(1), CNT_W'(2): lsq_nxt = lsq_r + prod_r[SQ_W-1:0];
          CNT_W'(3), CNT_W'(4): dot_nxt = dot_r + $signed(prod_r[SUM_W-1:0]);
          CNT_W'(5): cross_nxt = cross_r + $signed(prod_r[SUM_W-1:0]);
          CNT_W'(6): cross_nxt = cross_r - $signed(prod_r[SUM_W-1:0]);
          default: ;
        endcase
        if (step_r == CNT_W'(N_PROD)) begin
          step_nxt  = '0;
          state_nxt = S_PICK;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_PICK: begin
        step_nxt = '0;
        acc_nxt  = '0;
        if (lsq_r == '0 || dot_r[SUM_W-1] || dot_r == '0) begin
          state_nxt = S_PSQ;
        end else if (dot_r >= lsq_s) begin
          // nearest point is the second end
          wx_nxt    = vx_r;
          wy_nxt    = vy_r;
          state_nxt = S_PSQ;
        end else begin
          mag_nxt   = cross_r[SUM_W-1] ? cross_neg[SQ_W-1:0] : cross_r[SQ_W-1:0];
          state_nxt = S_MSQ;
        end
      end
      S_PSQ: begin
        if (step_r != '0) begin
          acc_nxt = acc_sum;
        end
        if (step_r == CNT_W'(N_PSQ)) begin
          rad_nxt   = acc_sum[SQ_W-1:0];
          root_nxt  = '0;
          srem_nxt  = '0;
          step_nxt  = '0;
          state_nxt = S_ROOT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_MSQ: begin
        if (step_r != '0) begin
          acc_nxt = acc_sum;
        end
        if (step_r == CNT_W'(N_MSQ)) begin
          // quotient fits in SQ_W bits, so the top half starts as remainder
          rem_nxt   = acc_sum[NUM_W-1:SQ_W];
          quo_nxt   = '0;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_DIV: begin
        rem_nxt = div_ge ? div_diff[SQ_W-1:0] : div_trial[SQ_W-1:0];
        acc_nxt = acc_r << 1;
        quo_nxt = {quo_r[SQ_W-2:0], div_ge};
        if (step_r == CNT_W'(SQ_W - 1)) begin
          rad_nxt   = {quo_r[SQ_W-2:0], div_ge};
          root_nxt  = '0;
          srem_nxt  = '0;
          step_nxt  = '0;
          state_nxt = S_ROOT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_ROOT: begin
        srem_nxt = sq_ge ? sq_diff[SREM_W-1:0] : sq_sh[SREM_W-1:0];
        root_nxt = root_step;
        rad_nxt  = rad_r << 2;
        if (step_r == CNT_W'(ROOT_W - 1)) begin
          dist_nxt  = (|root_step[ROOT_W-1:DIST_W]) ? DIST_MAX : root_step[DIST_W-1:0];
          step_nxt  = '0;
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
    ux_r    <= ux_nxt;
    uy_r    <= uy_nxt;
    wx_r    <= wx_nxt;
    wy_r    <= wy_nxt;
    vx_r    <= vx_nxt;
    vy_r    <= vy_nxt;
    lsq_r   <= lsq_nxt;
    dot_r   <= dot_nxt;
    cross_r <= cross_nxt;
    prod_r  <= prod_nxt;
    mag_r   <= mag_nxt;
    acc_r   <= acc_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    rad_r   <= rad_nxt;
    root_r  <= root_nxt;
    srem_r  <= srem_nxt;
    dist_r  <= dist_nxt;
  end

  assign sts.done     = (state_r == S_DONE);
  assign sts.distance = dist_r;

endmodule

FILE: rtl/core/nearest_segment_pick_unit.sv
// ----------------------------------------------------------------------------
// nearest_segment_pick_unit - nearest segment to a pointer
// Tracks the segment nearest to the configured pointer over a query and
// returns found flag, owner and distance on the query's last segment.
// ----------------------------------------------------------------------------
// One segment word is worked on at a time; in_stall stays high until its
// distance is known. A segment whose nearest point is one of its ends, or
// which has zero length, skips the divider; one whose nearest point lies
// inside it needs the divider too. The time per segment is set by the
// single shared 26x26 multiplier (six products, then two or three more), the
// 50-step restoring divider and the 25-step square root of the distance unit.
// The last segment of a query also passes a state that loads the result word,
// which waits while the previous result word is still stalled. Results are
// Euclidean distances in Q16.8, rounded down and saturated; a segment wins
// only when strictly nearer than the best so far, starting from pick_radius
// as it stood when the query opened. Configuration writes take effect at once.
module nearest_segment_pick_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  nsp_pkg::nsp_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output nsp_pkg::nsp_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [nsp_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [nsp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import nsp_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_EMIT} state_t;

  state_t                     state_r, state_nxt;
  logic signed [COORD_W-1:0]  ptr_x_r, ptr_x_nxt;
  logic signed [COORD_W-1:0]  ptr_y_r, ptr_y_nxt;
  logic [DIST_W-1:0]          radius_r, radius_nxt;
  logic                       query_open_r, query_open_nxt;
  logic [DIST_W-1:0]          best_dist_r, best_dist_nxt;
  logic [OWNER_W-1:0]         best_owner_r, best_owner_nxt;
  logic                       any_hit_r, any_hit_nxt;
  logic [OWNER_W-1:0]         owner_r, owner_nxt;
  logic                       last_r, last_nxt;
  logic                       out_valid_r, out_valid_nxt;
  nsp_out_t                   out_data_r, out_data_nxt;

  logic                       accept;
  nsp_geom_t                  geom;
  nsp_sts_t                   sts;

  assign accept = in_valid && (state_r == ST_IDLE);

  assign geom.start_x = in_data.start_x;
  assign geom.start_y = in_data.start_y;
  assign geom.end_x   = in_data.end_x;
  assign geom.end_y   = in_data.end_y;
  assign geom.ptr_x   = ptr_x_r;
  assign geom.ptr_y   = ptr_y_r;

  nsp_dist_unit u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .geom  (geom),
    .sts   (sts)
  );

  always_comb begin
    state_nxt      = state_r;
    ptr_x_nxt      = ptr_x_r;
    ptr_y_nxt      = ptr_y_r;
    radius_nxt     = radius_r;
    query_open_nxt = query_open_r;
    best_dist_nxt  = best_dist_r;
    best_owner_nxt = best_owner_r;
    any_hit_nxt    = any_hit_r;
    owner_nxt      = owner_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_POINTER_X:   ptr_x_nxt  = $signed(cfg_data[COORD_W-1:0]);
        CFG_POINTER_Y:   ptr_y_nxt  = $signed(cfg_data[COORD_W-1:0]);
        CFG_PICK_RADIUS: radius_nxt = cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end

    // result word taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          owner_nxt = in_data.owner_id;
          last_nxt  = in_data.last_segment;
          if (!query_open_r) begin
            best_dist_nxt  = radius_r;
            best_owner_nxt = '0;
            any_hit_nxt    = 1'b0;
            query_open_nxt = 1'b1;
          end
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (sts.done) begin
          if (sts.distance < best_dist_r) begin
            best_dist_nxt  = sts.distance;
            best_owner_nxt = owner_r;
            any_hit_nxt    = 1'b1;
          end
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.hit_found    = any_hit_r;
          out_data_nxt.hit_owner    = any_hit_r ? best_owner_r : '0;
          out_data_nxt.hit_distance = any_hit_r ? best_dist_r : '0;
          query_open_nxt            = 1'b0;
          state_nxt                 = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ptr_x_r      <= '0;
      ptr_y_r      <= '0;
      radius_r     <= RADIUS_RESET;
      query_open_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ptr_x_r      <= ptr_x_nxt;
      ptr_y_r      <= ptr_y_nxt;
      radius_r     <= radius_nxt;
      query_open_r <= query_open_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    best_dist_r  <= best_dist_nxt;
    best_owner_r <= best_owner_nxt;
    any_hit_r    <= any_hit_nxt;
    owner_r      <= owner_nxt;
    last_r       <= last_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb - nearest segment pick unit testbench
// Streams queries of line segments through the unit under random input gaps
// and output stalls, tracks the nearest segment to the pointer in a local
// model and checks every result word field by field. Pointer and radius are
// changed between phases, including while a query is still open.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import nsp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam int SETTLE_CYCLES = 120;   // above the time of the slowest segment
  localparam int HOLD_CYCLES   = 400;
  localparam int RAND_PHASES   = 9;
  localparam int HOLD_PHASE    = 4;
  localparam int PHASE_SEGS    = 58;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  nsp_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  nsp_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  nearest_segment_pick_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the registers and the running best
  logic signed [COORD_W-1:0] ptr_x_q = '0;
  logic signed [COORD_W-1:0] ptr_y_q = '0;
  logic [DIST_W-1:0] radius_q = RADIUS_RESET;
  logic [DIST_W-1:0] best_dist = RADIUS_RESET;
  logic [OWNER_W-1:0] best_owner = '0;
  logic any_hit = 1'b0;
  logic query_live = 1'b0;

  nsp_in_t seg_backlog[$];
  nsp_out_t expected_hits[$];
  int items_queued = 0;
  int segs_accepted = 0;
  int queries_closed = 0;
  int hit_queries = 0;
  int cfg_writes = 0;
  int results_seen = 0;
  int error_count = 0;
  int hold_requests = 0;

  // floor of the Euclidean pointer to segment distance, saturated
  function automatic logic [DIST_W-1:0] seg_pointer_distance(
    longint ax, longint ay, longint bx, longint by, longint px, longint py);
    longint ux, uy, wx, wy, lsq, dot, cross_v;
    logic [63:0] mag;
    logic [127:0] num, den, quot, t, r;
    ux = bx - ax;
    uy = by - ay;
    wx = px - ax;
    wy = py - ay;
    lsq = ux * ux + uy * uy;
    dot = wx * ux + wy * uy;
    den = 128'd1;
    if (lsq == 0 || dot <= 0) begin
      num = 128'(wx * wx + wy * wy);
    end else if (dot >= lsq) begin
      num = 128'((px - bx) * (px - bx) + (py - by) * (py - by));
    end else begin
      cross_v = wx * uy - wy * ux;
      mag = (cross_v < 0) ? 64'(-cross_v) : 64'(cross_v);
      num = 128'(mag) * 128'(mag);
      den = 128'(lsq);
    end
    quot = num / den;
    r = '0;
    for (int b = 26; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= quot) r = t;
    end
    if (r > 128'(DIST_MAX)) r = 128'(DIST_MAX);
    return r[DIST_W-1:0];
  endfunction

  task automatic track_nearest(input nsp_in_t s);
    logic [DIST_W-1:0] d;
    nsp_out_t w;
    if (!query_live) begin
      best_dist = radius_q;
      best_owner = '0;
      any_hit = 1'b0;
      query_live = 1'b1;
    end
    d = seg_pointer_distance($signed(s.start_x), $signed(s.start_y), $signed(s.end_x),
                             $signed(s.end_y), ptr_x_q, ptr_y_q);
    if (d < best_dist) begin
      best_dist = d;
      best_owner = s.owner_id;
      any_hit = 1'b1;
    end
    if (s.last_segment) begin
      w.hit_found = any_hit;
      w.hit_owner = any_hit ? best_owner : '0;
      w.hit_distance = any_hit ? best_dist : '0;
      expected_hits = {expected_hits, w};
      query_live = 1'b0;
      queries_closed++;
      if (any_hit) hit_queries++;
    end
  endtask

  // sender: bursts of words with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_nearest(in_data);
        segs_accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (seg_backlog.size() != 0) begin
          in_data <= seg_backlog.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 100);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks result words and stalls on its own pattern
  int stall_pct = 0;
  int pattern_left = 0;
  int hold_left = 0;
  int holds_served = 0;
  always @(posedge clk) begin
    nsp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_hits.size() == 0) begin
        $error("result word with no query closed: found %0d owner %0d distance %0d",
               out_data.hit_found, out_data.hit_owner, out_data.hit_distance);
        error_count++;
      end else begin
        want = expected_hits.pop_front();
        if (out_data.hit_found !== want.hit_found) begin
          $error("hit_found: expected %0d, got %0d", want.hit_found, out_data.hit_found);
          error_count++;
        end
        if (out_data.hit_owner !== want.hit_owner) begin
          $error("hit_owner: expected %0d, got %0d", want.hit_owner, out_data.hit_owner);
          error_count++;
        end
        if (out_data.hit_distance !== want.hit_distance) begin
          $error("hit_distance: expected %0d, got %0d", want.hit_distance,
                 out_data.hit_distance);
          error_count++;
        end
      end
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_served < hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(16, 128);
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 30;
          3: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      pattern_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      CFG_POINTER_X: ptr_x_q = val;
      CFG_POINTER_Y: ptr_y_q = val;
      CFG_PICK_RADIUS: radius_q = val;
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // pause until every queued word is taken and every result is back
  task automatic wait_drained();
    do @(posedge clk);
    while (segs_accepted != items_queued || expected_hits.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_seg(input int ax, input int ay, input int bx, input int by,
                           input int owner, input bit last);
    nsp_in_t s;
    s.start_x = COORD_W'(ax);
    s.start_y = COORD_W'(ay);
    s.end_x = COORD_W'(bx);
    s.end_y = COORD_W'(by);
    s.owner_id = OWNER_W'(owner);
    s.last_segment = last;
    seg_backlog = {seg_backlog, s};
    items_queued++;
  endtask

  function automatic int rand_offset(input int reach);
    return int'($urandom_range(0, 2 * reach)) - reach;
  endfunction

  // mostly segments around the pointer, some anywhere in the coordinate range
  function automatic nsp_in_t make_segment();
    nsp_in_t s;
    int reach, cx, cy, sx, sy;
    reach = (radius_q > 24'd1048576) ? 2097152 : 2 * int'(radius_q) + 256;
    cx = int'(ptr_x_q);
    cy = int'(ptr_y_q);
    sx = cx + rand_offset(reach);
    sy = cy + rand_offset(reach);
    s.start_x = COORD_W'(sx);
    s.start_y = COORD_W'(sy);
    case ($urandom_range(0, 9))
      0: begin
        s.start_x = COORD_W'($urandom);
        s.start_y = COORD_W'($urandom);
        s.end_x = COORD_W'($urandom);
        s.end_y = COORD_W'($urandom);
      end
      1: begin
        s.end_x = s.start_x;
        s.end_y = s.start_y;
      end
      2, 3: begin
        // ends on opposite sides so the nearest point falls inside
        s.end_x = COORD_W'(2 * cx - sx + rand_offset(reach / 4));
        s.end_y = COORD_W'(2 * cy - sy + rand_offset(reach / 4));
      end
      default: begin
        s.end_x = COORD_W'(cx + rand_offset(reach));
        s.end_y = COORD_W'(cy + rand_offset(reach));
      end
    endcase
    s.owner_id = OWNER_W'($urandom_range(0, 65535));
    s.last_segment = 1'b0;
    return s;
  endfunction

  task automatic queue_query(input int n_segs, input bit close);
    nsp_in_t s, prev;
    prev = '0;
    for (int i = 0; i < n_segs; i++) begin
      if (i > 0 && $urandom_range(0, 7) == 0) begin
        // same geometry again, so the first one must keep the tie
        s = prev;
        s.owner_id = OWNER_W'($urandom_range(0, 65535));
      end else begin
        s = make_segment();
      end
      s.last_segment = close && (i == n_segs - 1);
      seg_backlog = {seg_backlog, s};
      items_queued++;
      prev = s;
    end
  endtask

  task automatic random_settings();
    logic [CFG_DATA_W-1:0] px, py, rad;
    px = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF)
                                     : CFG_DATA_W'($urandom);
    py = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF)
                                     : CFG_DATA_W'($urandom);
    case ($urandom_range(0, 6))
      0: rad = RADIUS_RESET;
      1: rad = '0;
      2: rad = DIST_MAX;
      3: rad = CFG_DATA_W'($urandom);
      default: rad = CFG_DATA_W'($urandom_range(1, 65535));
    endcase
    if ($urandom_range(0, 1)) begin
      cfg_write(CFG_PICK_RADIUS, rad);
      cfg_write(CFG_POINTER_X, px);
    end else begin
      cfg_write(CFG_POINTER_X, px);
      cfg_write(CFG_PICK_RADIUS, rad);
    end
    cfg_write(CFG_POINTER_Y, py);
    if ($urandom_range(0, 2) == 0) cfg_write(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
  endtask

  initial begin
    int count, n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: pointer at origin, radius 8 px
    queue_seg(100, 0, 100, 0, 16'hFFFF, 1);                 // one-segment query
    queue_seg(2048, 0, 2048, 0, 5, 1);                      // exactly at the radius
    queue_seg(-500, 300, 500, 300, 7, 0);                   // inside, distance 300
    queue_seg(300, -1000, 300, 1000, 8, 0);                 // tie at 300
    queue_seg(1000, 1000, 2000, 2000, 9, 0);                // nearest at first end
    queue_seg(-3000, -3000, -3000, -2500, 10, 1);           // nearest at second end
    queue_seg(-8388608, -8388608, 8388607, 8388607, 0, 0);  // full diagonal, owner zero
    queue_seg(8388607, -8388608, 8388607, -8388608, 16'hFFFF, 1);
    wait_drained();

    // pointer in a corner, radius at its top
    cfg_write(CFG_POINTER_X, 24'h800000);
    cfg_write(CFG_POINTER_Y, 24'h7FFFFF);
    cfg_write(CFG_PICK_RADIUS, DIST_MAX);
    cfg_write(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
    queue_seg(8388607, -8388608, 8388607, -8388608, 1, 1);  // saturated distance
    queue_seg(8388607, 8388607, 8388607, 8388607, 1, 0);    // just at the top value
    queue_seg(8388606, 8388607, 8388606, 8388607, 2, 1);    // one below it
    queue_seg(-8388608, 8388607, 0, 0, 3, 0);               // query left open
    wait_drained();

    // settings change while the query is still open
    cfg_write(CFG_POINTER_X, 24'd0);
    cfg_write(CFG_POINTER_Y, 24'd0);
    cfg_write(CFG_PICK_RADIUS, 24'd0);
    queue_seg(10, 10, 10, 10, 4, 1);
    queue_seg(-100, 0, 100, 0, 6, 1);                       // zero radius, no hit
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_settings();
      if (ph == HOLD_PHASE) begin
        // long receiver hold while one-segment queries keep coming
        hold_requests++;
        for (int i = 0; i < 10; i++) queue_query(1, 1);
      end else begin
        count = 0;
        while (count < PHASE_SEGS) begin
          n = $urandom_range(1, 8);
          queue_query(n, 1);
          count += n;
        end
        if ($urandom_range(0, 2) == 0) queue_query($urandom_range(1, 3), 0);
      end
      wait_drained();
    end

    $display("%0d segments accepted, %0d queries closed (%0d with a hit), %0d results checked",
             segs_accepted, queries_closed, hit_queries, results_seen);
    $display("%0d register writes across %0d setting phases, %0d long receiver holds",
             cfg_writes, RAND_PHASES + 3, holds_served);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/nsp_pkg.sv
rtl/core/nsp_dist_unit.sv
rtl/core/nearest_segment_pick_unit.sv
bench/tb.sv
